// ===== rtl/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg: shared types and constants
// Widths of point, node and distance words, and the controller/datapath
// command and status records of the single-linkage clustering core.
// ----------------------------------------------------------------------------
package slc_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_W        = 16;
    localparam int POINT_W        = 2 * COORD_W;
    localparam int IDX_W          = 7;
    localparam int MCNT_W         = 6;
    localparam int CNT_W          = 7;
    localparam int DIST_W         = 36;
    localparam int ROOT_W         = 17;
    localparam int OUT_W          = 40;

    // distance write source
    localparam logic WSEL_SQDIST = 1'b0;
    localparam logic WSEL_MIN    = 1'b1;

    typedef struct packed {
        logic               pt_we;
        logic [IDX_W-1:0]   pt_addr;
        logic [POINT_W-1:0] pt_wdata;
        logic               pa_ld;
        logic               d_we;
        logic               d_wsel;
        logic [IDX_W-1:0]   d_wrow;
        logic [IDX_W-1:0]   d_wcol;
        logic [IDX_W-1:0]   d_rrow;
        logic [IDX_W-1:0]   d_rcol;
        logic               a_ld;
        logic               scan_clr;
        logic               cmp_en;
        logic [IDX_W-1:0]   cand_x;
        logic [IDX_W-1:0]   cand_y;
        logic [IDX_W-1:0]   sz_raddr;
        logic               sa_ld;
        logic               sz_we;
        logic [IDX_W-1:0]   sz_waddr;
        logic               used_set;
        logic               used_clr;
        logic [IDX_W-1:0]   used_x;
        logic [IDX_W-1:0]   used_y;
        logic               sqrt_start;
        logic               out_ld;
        logic               out_last;
        logic [IDX_W-1:0]   n;
    } t_cmd;

    typedef struct packed {
        logic             used_x;
        logic             used_y;
        logic [IDX_W-1:0] bx;
        logic [IDX_W-1:0] by;
        logic             sqrt_busy;
        logic             out_full;
    } t_stat;

endpackage

// ===== rtl/slc_ram.sv =====
// ----------------------------------------------------------------------------
// slc_ram: generic single-port-write ram
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/slc_isqrt.sv =====
// ----------------------------------------------------------------------------
// slc_isqrt: iterative floor square root
// Digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
module slc_isqrt import slc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIST_W-1:0] i_value,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    localparam logic [DIST_W-1:0] TOP_BIT = DIST_W'(1) << (DIST_W - 2);

    logic [DIST_W-1:0] r_v, r_r, r_bit;
    logic              r_busy;
    logic [DIST_W-1:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit == DIST_W'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= TOP_BIT;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_r[ROOT_W-1:0];

endmodule

// ===== rtl/slc_dp.sv =====
// ----------------------------------------------------------------------------
// slc_dp: clustering datapath
// Point, distance and size memories, squared-distance pipe, minimum scan
// registers, used flags, square root unit and the output word register.
// ----------------------------------------------------------------------------
module slc_dp import slc_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // first[6:0] second[13:7] dist[30:14] count[37:31]
    output logic              m_axis_tlast
);

    localparam int PW    = $clog2(MAX_POINTS);
    localparam int NODES = 2 * MAX_POINTS;
    localparam int NW    = $clog2(NODES);

    logic [POINT_W-1:0] pt_rdata;
    logic [DIST_W-1:0]  d_rdata, d_wdata, d_min;
    logic [CNT_W-1:0]   sz_rdata, cnt;

    logic [POINT_W-1:0] r_pa;
    logic [COORD_W:0]   r_dx, r_dy;
    logic [DIST_W-1:0]  r_sx, r_sy, r_a, r_best;
    logic               r_found;
    logic [IDX_W-1:0]   r_bx, r_by;
    logic [CNT_W-1:0]   r_sa, r_cnt;
    logic [NODES-1:0]   r_used;
    logic               sqrt_busy;
    logic [ROOT_W-1:0]  root;

    logic               r_ovalid, r_olast;
    logic [OUT_W-1:0]   r_odata;

    logic signed [COORD_W:0] dx, dy;

    slc_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pt_we),
        .i_waddr (i_cmd.pt_addr[PW-1:0]),
        .i_wdata (i_cmd.pt_wdata),
        .i_raddr (i_cmd.pt_addr[PW-1:0]),
        .o_rdata (pt_rdata)
    );

    // upper triangle only: row below column
    slc_ram #(.WIDTH(DIST_W), .DEPTH((2 ** NW) * (2 ** NW))) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.d_we),
        .i_waddr ({i_cmd.d_wrow[NW-1:0], i_cmd.d_wcol[NW-1:0]}),
        .i_wdata (d_wdata),
        .i_raddr ({i_cmd.d_rrow[NW-1:0], i_cmd.d_rcol[NW-1:0]}),
        .o_rdata (d_rdata)
    );

    slc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_POINTS)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.sz_we),
        .i_waddr (i_cmd.sz_waddr[PW-1:0]),
        .i_wdata (cnt),
        .i_raddr (i_cmd.sz_raddr[PW-1:0]),
        .o_rdata (sz_rdata)
    );

    slc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (r_best),
        .o_busy  (sqrt_busy),
        .o_root  (root)
    );

    // squared distance pipe: diff, square, sum
    assign dx = $signed({r_pa[COORD_W-1], r_pa[COORD_W-1:0]})
              - $signed({pt_rdata[COORD_W-1], pt_rdata[COORD_W-1:0]});
    assign dy = $signed({r_pa[POINT_W-1], r_pa[POINT_W-1:COORD_W]})
              - $signed({pt_rdata[POINT_W-1], pt_rdata[POINT_W-1:COORD_W]});

    assign d_min   = (r_a < d_rdata) ? r_a : d_rdata;
    assign d_wdata = (i_cmd.d_wsel == WSEL_MIN) ? d_min : r_sx + r_sy;
    assign cnt     = r_sa + ((r_by < i_cmd.n) ? CNT_W'(1) : sz_rdata);

    always_ff @(posedge i_clk) begin
        if (i_cmd.pa_ld) begin
            r_pa <= pt_rdata;
        end
        r_dx <= dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
        r_dy <= dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
        r_sx <= DIST_W'(r_dx * r_dx);
        r_sy <= DIST_W'(r_dy * r_dy);
        if (i_cmd.a_ld) begin
            r_a <= d_rdata;
        end
        if (i_cmd.sa_ld) begin
            r_sa <= (r_bx < i_cmd.n) ? CNT_W'(1) : sz_rdata;
        end
        if (i_cmd.sz_we) begin
            r_cnt <= cnt;
        end
        // later pair wins ties
        if (i_cmd.cmp_en && (!r_found || d_rdata <= r_best)) begin
            r_best <= d_rdata;
            r_bx   <= i_cmd.cand_x;
            r_by   <= i_cmd.cand_y;
        end
        if (i_cmd.out_ld) begin
            r_odata <= {2'b00, r_cnt, root, r_by, r_bx};
            r_olast <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found  <= 1'b0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.scan_clr) begin
                r_found <= 1'b0;
            end else if (i_cmd.cmp_en) begin
                r_found <= 1'b1;
            end
            if (i_cmd.used_clr) begin
                r_used <= '0;
            end else if (i_cmd.used_set) begin
                r_used[r_bx[NW-1:0]] <= 1'b1;
                r_used[r_by[NW-1:0]] <= 1'b1;
            end
            if (i_cmd.out_ld) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stat.used_x    = r_used[i_cmd.used_x[NW-1:0]];
    assign o_stat.used_y    = r_used[i_cmd.used_y[NW-1:0]];
    assign o_stat.bx        = r_bx;
    assign o_stat.by        = r_by;
    assign o_stat.sqrt_busy = sqrt_busy;
    assign o_stat.out_full  = r_ovalid;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld |-> !r_ovalid)
        else $error("output word overwritten");
    a_sqrt_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqrt_start |-> !sqrt_busy)
        else $error("square root restarted while busy");
    a_out_root_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld |-> !sqrt_busy && r_found)
        else $error("merge emitted before its distance is ready");
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.used_set |-> r_bx < r_by)
        else $error("merged pair out of order");

endmodule

// ===== rtl/slc_ctrl.sv =====
// ----------------------------------------------------------------------------
// slc_ctrl: clustering sequencer
// Load, distance-table build, minimum scan, size update, linkage update
// and result hand-off, with all loop indices.
// ----------------------------------------------------------------------------
module slc_ctrl import slc_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [POINT_W-1:0] s_axis_tdata,
    input  logic               s_axis_tlast,
    output t_cmd               o_cmd,
    input  t_stat              i_stat
);

    typedef enum logic [14:0] {
        S_LOAD = 15'b000000000000001,
        S_DA   = 15'b000000000000010,
        S_DB   = 15'b000000000000100,
        S_DC   = 15'b000000000001000,
        S_DD   = 15'b000000000010000,
        S_DE   = 15'b000000000100000,
        S_SCAN = 15'b000000001000000,
        S_CMP  = 15'b000000010000000,
        S_SZA  = 15'b000000100000000,
        S_SZB  = 15'b000001000000000,
        S_SZC  = 15'b000010000000000,
        S_UA   = 15'b000100000000000,
        S_UB   = 15'b001000000000000,
        S_UC   = 15'b010000000000000,
        S_OUT  = 15'b100000000000000
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_cnt, n_cnt, r_n, n_n, r_i, n_i, r_j, n_j;
    logic [MCNT_W-1:0] r_m, n_m;
    logic [IDX_W-1:0]  limit, cnt_inc;
    logic              scan_last;

    assign limit     = r_n + IDX_W'(r_m);
    assign scan_last = (r_i == limit - IDX_W'(2)) && (r_j == limit - IDX_W'(1));
    assign cnt_inc   = (r_cnt < IDX_W'(MAX_POINTS)) ? r_cnt + IDX_W'(1) : r_cnt;

    always_comb begin
        o_cmd          = '0;
        o_cmd.n        = r_n;
        o_cmd.used_x   = r_i;
        o_cmd.used_y   = r_j;
        o_cmd.cand_x   = r_i;
        o_cmd.cand_y   = r_j;
        o_cmd.pt_wdata = s_axis_tdata;
        s_axis_tready  = 1'b0;
        n_state = r_state;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_i     = r_i;
        n_j     = r_j;
        n_m     = r_m;
        unique case (r_state)
            S_LOAD: begin
                s_axis_tready = 1'b1;
                o_cmd.pt_addr = r_cnt;
                if (s_axis_tvalid) begin
                    o_cmd.pt_we = (r_cnt < IDX_W'(MAX_POINTS));
                    n_cnt = cnt_inc;
                    if (s_axis_tlast) begin
                        n_cnt = '0;
                        if (cnt_inc >= IDX_W'(2)) begin
                            n_n     = cnt_inc;
                            n_i     = '0;
                            n_j     = IDX_W'(1);
                            n_state = S_DA;
                        end
                    end
                end
            end
            S_DA: begin
                o_cmd.pt_addr = r_i;
                n_state = S_DB;
            end
            S_DB: begin
                o_cmd.pa_ld   = 1'b1;
                o_cmd.pt_addr = r_j;
                n_state = S_DC;
            end
            S_DC: n_state = S_DD;
            S_DD: n_state = S_DE;
            S_DE: begin
                o_cmd.d_we   = 1'b1;
                o_cmd.d_wsel = WSEL_SQDIST;
                o_cmd.d_wrow = r_i;
                o_cmd.d_wcol = r_j;
                n_state = S_DA;
                if (r_j == r_n - IDX_W'(1)) begin
                    if (r_i == r_n - IDX_W'(2)) begin
                        o_cmd.scan_clr = 1'b1;
                        n_m     = '0;
                        n_i     = '0;
                        n_j     = IDX_W'(1);
                        n_state = S_SCAN;
                    end else begin
                        n_i = r_i + IDX_W'(1);
                        n_j = r_i + IDX_W'(2);
                    end
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            S_SCAN, S_CMP: begin
                o_cmd.d_rrow = r_i;
                o_cmd.d_rcol = r_j;
                if (r_state == S_SCAN && !i_stat.used_x && !i_stat.used_y) begin
                    n_state = S_CMP;
                end else begin
                    o_cmd.cmp_en = (r_state == S_CMP);
                    n_state = S_SCAN;
                    if (scan_last) begin
                        n_state = S_SZA;
                    end else if (r_j == limit - IDX_W'(1)) begin
                        n_i = r_i + IDX_W'(1);
                        n_j = r_i + IDX_W'(2);
                    end else begin
                        n_j = r_j + IDX_W'(1);
                    end
                end
            end
            S_SZA: begin
                o_cmd.sz_raddr = i_stat.bx - r_n;
                n_state = S_SZB;
            end
            S_SZB: begin
                o_cmd.sa_ld    = 1'b1;
                o_cmd.sz_raddr = i_stat.by - r_n;
                n_state = S_SZC;
            end
            S_SZC: begin
                o_cmd.sz_we      = 1'b1;
                o_cmd.sz_waddr   = IDX_W'(r_m);
                o_cmd.used_set   = 1'b1;
                o_cmd.sqrt_start = 1'b1;
                n_i     = '0;
                n_state = S_UA;
            end
            S_UA, S_UB, S_UC: begin
                // row below column in the triangle
                if (r_state == S_UB) begin
                    o_cmd.d_rrow = (r_i < i_stat.by) ? r_i : i_stat.by;
                    o_cmd.d_rcol = (r_i < i_stat.by) ? i_stat.by : r_i;
                end else begin
                    o_cmd.d_rrow = (r_i < i_stat.bx) ? r_i : i_stat.bx;
                    o_cmd.d_rcol = (r_i < i_stat.bx) ? i_stat.bx : r_i;
                end
                o_cmd.a_ld   = (r_state == S_UB);
                o_cmd.d_we   = (r_state == S_UC);
                o_cmd.d_wsel = WSEL_MIN;
                o_cmd.d_wrow = r_i;
                o_cmd.d_wcol = limit;
                if (r_state == S_UA && !i_stat.used_x) begin
                    n_state = S_UB;
                end else if (r_state == S_UB) begin
                    n_state = S_UC;
                end else if (r_i == limit - IDX_W'(1)) begin
                    n_state = S_OUT;
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = S_UA;
                end
            end
            S_OUT: begin
                o_cmd.out_last = (IDX_W'(r_m) == r_n - IDX_W'(2));
                if (!i_stat.sqrt_busy && !i_stat.out_full) begin
                    o_cmd.out_ld = 1'b1;
                    if (o_cmd.out_last) begin
                        o_cmd.used_clr = 1'b1;
                        n_m     = '0;
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.scan_clr = 1'b1;
                        n_m     = r_m + MCNT_W'(1);
                        n_i     = '0;
                        n_j     = IDX_W'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_m     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_m     <= n_m;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;
        r_i <= n_i;
        r_j <= n_j;
    end

endmodule

// ===== rtl/single_linkage_clustering_core.sv =====
// ----------------------------------------------------------------------------
// single_linkage_clustering_core: single-linkage agglomerative clustering
// Loads a run of signed Q12.4 points, builds the squared-distance table and
// emits one word per merge: members, floor root distance, member count.
// ----------------------------------------------------------------------------
//  channel   dir  fields (lsb first)                          end marker
//  s_axis    in   point_x[15:0] point_y[31:16]                tlast = last_point
//  m_axis    out  first[6:0] second[13:7] dist[30:14] cnt[37:31]  tlast = last_merge
//
//  loading accepts one point per cycle; a run of n points then builds the
//  distance table through states DA to DE per pair, one memory write per pair
//  each merge k scans every pair below n+k: a pair with a used member passes
//  S_SCAN only, a live pair also S_CMP (one distance memory read port)
//  each merge adds size states SZA to SZC, linkage states UA to UC per node
//  (UA only if used) and the hand-off state; the root overlaps the update
//  reset is synchronous; no clearing pass, used flags reset at once
//  input is held off from the last point until the final merge word is
//  registered; a stalled output only holds the sequencer in its hand-off state
// ----------------------------------------------------------------------------
module single_linkage_clustering_core import slc_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // point words
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [POINT_W-1:0] s_axis_tdata,   // point_x[15:0] point_y[31:16]
    input  logic               s_axis_tlast,
    // merge words
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_W-1:0]   m_axis_tdata,   // first_member[6:0] second_member[13:7]
                                               // merge_distance[30:14] member_count[37:31]
    output logic               m_axis_tlast
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: owns all loop indices and the run length
    slc_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_cmd         (cmd),
        .i_stat        (stat)
    );

    // memories, arithmetic and the output word register
    slc_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
